@@ src/smp_pkg.sv @@
// Shared types and constants for the SHA-2 message padder.
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [6:0] LEN_AT_NARROW = 7'd56;
  localparam logic [6:0] LEN_AT_WIDE   = 7'd112;
  localparam logic [7:0] BLK_NARROW    = 8'd64;
  localparam logic [7:0] BLK_WIDE      = 8'd128;
  localparam logic [3:0] TAIL_NARROW   = 4'd8;
  localparam logic [3:0] TAIL_WIDE     = 4'd0;
  localparam logic [3:0] TAIL_LAST     = 4'd15;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_TAIL
  } byte_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic      push;
    byte_sel_t sel;
    logic      count;
    logic      tail_start;
    logic      tail_step;
    logic      msg_end;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_len_field;
    logic tail_done;
  } status_t;

endpackage

`default_nettype wire

@@ src/smp_ctrl.sv @@
// Control state machine of the SHA-2 message padder.
`timescale 1ns / 1ps
`default_nettype none

module smp_ctrl
  import smp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire logic    byte_present,
  input  wire logic    message_last,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.sel        = SEL_DATA;
    in_stall       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = !status.out_free;
        if (in_valid && status.out_free) begin
          cmd.push  = byte_present;
          cmd.count = byte_present;
          if (message_last) begin
            state_next = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = SEL_MARK;
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        // Zero fill runs until the block position reaches the length field.
        if (status.at_len_field) begin
          cmd.tail_start = 1'b1;
          state_next     = ST_TAIL;
        end else if (status.out_free) begin
          cmd.push = 1'b1;
          cmd.sel  = SEL_ZERO;
        end
      end
      ST_TAIL: begin
        if (status.out_free) begin
          cmd.push      = 1'b1;
          cmd.sel       = SEL_TAIL;
          cmd.tail_step = 1'b1;
          if (status.tail_done) begin
            cmd.msg_end = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/smp_datapath.sv @@
// Byte packer, block position, byte count and output word register.
`timescale 1ns / 1ps
`default_nettype none

module smp_datapath
  import smp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        wide_mode,
  input  wire logic [7:0]  data_byte,
  input  wire cmd_t        cmd,
  output status_t          status,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      padded_word,
  output logic [3:0]       word_index,
  output logic             block_end,
  output logic             message_end
);

  logic        wide;
  logic [63:0] byte_count;
  logic [63:0] word_buffer;
  logic [6:0]  block_position;
  logic [3:0]  tail_count;

  logic [63:0] bit_length;
  logic [7:0]  push_byte;
  logic [6:0]  pos_m;
  logic [7:0]  pos_inc;
  logic        word_done;
  logic        blk_done;
  logic [63:0] buffer_next;
  logic [3:0]  index_next;
  logic [63:0] word_next;
  logic [6:0]  pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      wide <= wide_mode;
    end
  end

  assign bit_length = {byte_count[60:0], 3'b000};

  always_comb begin
    unique case (cmd.sel)
      SEL_DATA: push_byte = data_byte;
      SEL_MARK: push_byte = PAD_MARK_BYTE;
      SEL_ZERO: push_byte = 8'h00;
      SEL_TAIL: begin
        // The last eight tail bytes (the lower half in 1024-bit mode) are the big-endian bit length.
        if (tail_count[3]) begin
          push_byte = bit_length[(6'd63 - {tail_count[2:0], 3'b000}) -: 8];
        end else begin
          push_byte = 8'h00;
        end
      end
      default: push_byte = 8'h00;
    endcase
  end

  always_comb begin
    pos_m       = wide ? block_position : {1'b0, block_position[5:0]};
    pos_inc     = {1'b0, pos_m} + 8'd1;
    word_done   = wide ? (pos_inc[2:0] == 3'd0) : (pos_inc[1:0] == 2'd0);
    blk_done    = wide ? (pos_inc == BLK_WIDE) : (pos_inc == BLK_NARROW);
    buffer_next = {word_buffer[55:0], push_byte};
    index_next  = wide ? (pos_inc[6:3] - 4'd1) : (pos_inc[5:2] - 4'd1);
    word_next   = wide ? buffer_next : {32'd0, buffer_next[31:0]};
    pos_next    = blk_done ? 7'd0 : pos_inc[6:0];
  end

  assign status.out_free     = !out_valid || !out_stall;
  assign status.at_len_field = wide ? (pos_m == LEN_AT_WIDE) : (pos_m == LEN_AT_NARROW);
  assign status.tail_done    = (tail_count == TAIL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      word_buffer    <= '0;
      block_position <= '0;
      tail_count     <= '0;
    end else if (cmd.msg_end) begin
      byte_count     <= '0;
      word_buffer    <= '0;
      block_position <= '0;
      tail_count     <= '0;
    end else begin
      if (cmd.count) begin
        byte_count <= byte_count + 64'd1;
      end
      if (cmd.push) begin
        word_buffer    <= word_done ? 64'd0 : buffer_next;
        block_position <= pos_next;
      end
      if (cmd.tail_start) begin
        tail_count <= wide ? TAIL_WIDE : TAIL_NARROW;
      end else if (cmd.tail_step) begin
        tail_count <= tail_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push && word_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && word_done) begin
      padded_word <= word_next;
      word_index  <= index_next;
      block_end   <= blk_done;
      message_end <= cmd.msg_end;
    end
  end

endmodule

`default_nettype wire

@@ src/sha2_message_padder.sv @@
// Top level of the SHA-2 message padder for 512-bit and 1024-bit blocks.
//
//   Channel  Direction  Handshake             Word
//   in       input      in_valid / in_stall   data_byte, byte_present, message_last
//   out      output     out_valid / out_stall padded_word, word_index, block_end,
//                                             message_end
//   cfg      input      cfg_valid / cfg_ready wide_mode
//
// A byte word is taken whenever in_stall is low; words leave through a registered output stage.
// After a last word the padding sequencer pushes one pad byte a cycle while the output
// does not stall: the 0x80 mark, the zero fill up to the length field and a 16-byte
// tail (8 in 512-bit mode), plus a step to enter the tail in which no byte is pushed.
// Reset is synchronous and clears control state and the byte count.
// The input stalls during padding and whenever a full output word is held.
`timescale 1ns / 1ps
`default_nettype none

module sha2_message_padder
  import smp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        wide_mode,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        message_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      padded_word,
  output logic [3:0]       word_index,
  output logic             block_end,
  output logic             message_end
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  smp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_present (byte_present),
    .message_last (message_last),
    .status       (status),
    .cmd          (cmd)
  );

  smp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .wide_mode   (wide_mode),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .padded_word (padded_word),
    .word_index  (word_index),
    .block_end   (block_end),
    .message_end (message_end)
  );

endmodule

`default_nettype wire

@@ verif/sha2_message_padder_test.sv @@
// Self-checking testbench for the SHA-2 message padder in 512-bit and 1024-bit modes.
`timescale 1ns / 1ps

module sha2_message_padder_test;
  import smp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD     = 250;
  localparam int unsigned RANDOM_ITEMS  = 350;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  slot;
    logic        blk_end;
    logic        msg_end;
  } pad_word_t;

  typedef struct packed {
    logic        set_mode;
    logic        mode;
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        typed;
    logic [63:0] word;
  } dir_row_t;

  // Directed rows: a mode write (after draining) may precede a row, and where the
  // first word that a row causes is obvious it is typed in here.
  localparam int unsigned SCRIPT_ROWS = 19;
  localparam dir_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 64'h0000_0000_8000_0000},
    '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 64'h0000_0000_FF80_0000},
    '{1'b0, 1'b0, 8'h3C, 1'b0, 1'b0, 1'b0, 64'h0},
    '{1'b0, 1'b0, 8'hA5, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b0, 1'b0, 8'h5A, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b0, 1'b0, 8'h01, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b0, 1'b0, 8'hFE, 1'b1, 1'b1, 1'b1, 64'h0000_0000_A55A_01FE},
    '{1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
    '{1'b0, 1'b1, 8'h80, 1'b1, 1'b1, 1'b1, 64'h8080_0000_0000_0000},
    '{1'b0, 1'b1, 8'h12, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b0, 1'b1, 8'h34, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b0, 1'b1, 8'h56, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b1, 1'b0, 8'h78, 1'b1, 1'b0, 1'b1, 64'h0000_0000_1234_5678},
    '{1'b0, 1'b0, 8'h9A, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b1, 1'b1, 8'hBC, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b0, 1'b1, 8'hDE, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1'b0, 1'b1, 8'hF0, 1'b1, 1'b0, 1'b1, 64'h0000_0000_9ABC_DEF0},
    '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 64'h0},
    '{1'b0, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 64'h0}
  };

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        wide_mode;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        message_last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] padded_word;
  logic [3:0]  word_index;
  logic        block_end;
  logic        message_end;

  sha2_message_padder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .wide_mode    (wide_mode),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .message_last (message_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .padded_word  (padded_word),
    .word_index   (word_index),
    .block_end    (block_end),
    .message_end  (message_end)
  );

  // Padder state as predicted by the testbench.
  logic        pm_wide;
  logic [63:0] msg_len;
  logic [63:0] acc_word;
  int unsigned blk_pos;

  pad_word_t item_words[$];
  pad_word_t awaited_words[$];

  int          mismatches;
  int unsigned quiet_cycles;
  logic        steady;
  logic        long_hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void shift_in_byte(logic [7:0] b);
    int unsigned blk_bytes;
    int unsigned word_bytes;
    int unsigned pos;
    pad_word_t w;
    blk_bytes = pm_wide ? BLK_WIDE : BLK_NARROW;
    word_bytes = pm_wide ? 8 : 4;
    acc_word = {acc_word[55:0], b};
    pos = (blk_pos & (blk_bytes - 1)) + 1;
    if (pos % word_bytes == 0) begin
      w.word = pm_wide ? acc_word : {32'h0, acc_word[31:0]};
      w.slot = 4'(pos / word_bytes - 1);
      w.blk_end = (pos == blk_bytes);
      w.msg_end = 1'b0;
      item_words.push_back(w);
      acc_word = '0;
    end
    blk_pos = (pos == blk_bytes) ? 0 : pos;
  endfunction

  // Computes the words that one accepted byte word causes into item_words.
  function automatic void predict_item(logic [7:0] b, logic present, logic last);
    int unsigned len_at;
    int unsigned blk_bytes;
    logic [63:0] bit_len;
    int n;
    item_words.delete();
    len_at = pm_wide ? LEN_AT_WIDE : LEN_AT_NARROW;
    blk_bytes = pm_wide ? BLK_WIDE : BLK_NARROW;
    blk_pos = blk_pos & (blk_bytes - 1);
    if (present) begin
      msg_len = msg_len + 64'd1;
      shift_in_byte(b);
    end
    if (last) begin
      bit_len = msg_len << 3;
      shift_in_byte(PAD_MARK_BYTE);
      while (blk_pos != len_at) shift_in_byte(8'h00);
      // The upper half of the 128-bit length field is always zero.
      if (pm_wide) repeat (8) shift_in_byte(8'h00);
      for (int k = 7; k >= 0; k--) shift_in_byte(bit_len[k * 8 +: 8]);
      n = item_words.size();
      if (n > 0) item_words[n - 1].msg_end = 1'b1;
      msg_len = '0;
      acc_word = '0;
      blk_pos = 0;
    end
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  task automatic offer_item(logic [7:0] b, logic present, logic last, logic typed,
                            logic [63:0] typed_word);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= present;
    message_last <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_item(b, present, last);
    if (typed && item_words.size() > 0) item_words[0].word = typed_word;
    foreach (item_words[i]) awaited_words.push_back(item_words[i]);
  endtask

  // Waits until every awaited word is out, then long enough for a padding burst
  // that has produced no word yet to finish.
  task automatic drain_padder();
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_block_mode(logic m);
    drain_padder();
    cfg_valid <= 1'b1;
    wide_mode <= m;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    pm_wide = m;
  endtask

  // Word monitor: each accepted word is matched against the oldest expectation.
  always @(posedge clk) begin
    pad_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        mismatches++;
        $display("%0t: word with no expectation, expected none, actual %h slot %0d",
                 $time, padded_word, word_index);
      end else begin
        want = awaited_words.pop_front();
        check_field("padded_word", want.word, padded_word);
        check_field("word_index", 64'(want.slot), 64'(word_index));
        check_field("block_end", 64'(want.blk_end), 64'(block_end));
        check_field("message_end", 64'(want.msg_end), 64'(message_end));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("sha2_message_padder regression: fail");
    $finish;
  end

  // Output side: random stalls per word, plus one long hold-off to back up the padder.
  initial begin
    int unsigned hold;
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 8);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    int unsigned items_sent;
    int unsigned msg_bytes;
    int unsigned raw_count;
    logic end_with_byte;
    logic first;
    logic p;
    logic l;
    mismatches = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    long_hold_req = 1'b0;
    pm_wide = 1'b0;
    msg_len = '0;
    acc_word = '0;
    blk_pos = 0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    wide_mode <= 1'b0;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    byte_present <= 1'b0;
    message_last <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[r]) begin
      if (SCRIPT[r].set_mode) set_block_mode(SCRIPT[r].mode);
      offer_item(SCRIPT[r].data, SCRIPT[r].present, SCRIPT[r].last, SCRIPT[r].typed,
                 SCRIPT[r].word);
    end

    // The first random message is long so that the hold-off below fills the padder.
    long_hold_req = 1'b1;
    first = 1'b1;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) steady = ~steady;
      if (!first && $urandom_range(0, 3) == 0) set_block_mode(1'($urandom_range(0, 1)));
      if (!first && $urandom_range(0, 7) == 0) begin
        // Unstructured items; a message left open here is continued by the next one.
        raw_count = $urandom_range(1, 12);
        repeat (raw_count) begin
          p = 1'($urandom);
          l = 1'($urandom);
          offer_item(8'($urandom), p, l, 1'b0, 64'h0);
          if (p || l) items_sent++;
        end
      end else begin
        case ($urandom_range(0, 15))
          12, 13: begin
            case ($urandom_range(0, 9))
              0: msg_bytes = 55;
              1: msg_bytes = 56;
              2: msg_bytes = 57;
              3: msg_bytes = 63;
              4: msg_bytes = 64;
              5: msg_bytes = 111;
              6: msg_bytes = 112;
              7: msg_bytes = 113;
              8: msg_bytes = 120;
              default: msg_bytes = 128;
            endcase
          end
          14: msg_bytes = $urandom_range(0, 130);
          15: msg_bytes = $urandom_range(10, 40);
          default: msg_bytes = $urandom_range(0, 9);
        endcase
        if (first) msg_bytes = 70;
        end_with_byte = (msg_bytes > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < msg_bytes; i++) begin
          if ($urandom_range(0, 9) == 0) offer_item(8'($urandom), 1'b0, 1'b0, 1'b0, 64'h0);
          offer_item(8'($urandom), 1'b1, end_with_byte && (i == msg_bytes - 1), 1'b0, 64'h0);
          items_sent++;
        end
        if (!end_with_byte) begin
          offer_item(8'($urandom), 1'b0, 1'b1, 1'b0, 64'h0);
          items_sent++;
        end
      end
      first = 1'b0;
    end

    drain_padder();
    if (mismatches == 0)
      $display("sha2_message_padder regression: pass");
    else
      $display("sha2_message_padder regression: fail");
    $finish;
  end

endmodule

@@ sha2_message_padder.f @@
src/smp_pkg.sv
src/smp_ctrl.sv
src/smp_datapath.sv
src/sha2_message_padder.sv
verif/sha2_message_padder_test.sv
